// ===== hdl/rtpfu_pkg.sv =====
// shared types, constants and register map of the rtp fu-a packetizer
package rtpfu_pkg;

	// defaults of the top-level parameters
	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// configuration port
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SOURCE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_TYPE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_LIMIT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAGMENT_CHUNK = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMESTAMP_STEP = 3'd4;

	// register reset values
	localparam logic [31:0] DEF_SYNC_SOURCE    = 32'h6666_8899;
	localparam logic [6:0]  DEF_PAYLOAD_TYPE   = 7'd96;
	localparam logic [15:0] DEF_SINGLE_LIMIT   = 16'd1388;
	localparam logic [15:0] DEF_FRAGMENT_CHUNK = 16'd1400;
	localparam logic [15:0] DEF_TIMESTAMP_STEP = 16'(90000 / 25);

	// protocol constants
	localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
	localparam logic [4:0] FU_A_TYPE        = 5'd28;
	localparam logic [7:0] FU_START_BIT     = 8'h80;
	localparam logic [7:0] FU_END_BIT       = 8'h40;
	localparam logic [15:0] SEQ_RESET       = 16'd1;

	// byte positions walked by the back end for one command
	localparam int BYTE_IDX_W = 4;
	localparam logic [BYTE_IDX_W-1:0] IDX_HDR_FIRST = 4'd0;
	localparam logic [BYTE_IDX_W-1:0] IDX_HDR_LAST  = 4'd11;
	localparam logic [BYTE_IDX_W-1:0] IDX_FU_IND    = 4'd12;
	localparam logic [BYTE_IDX_W-1:0] IDX_FU_HDR    = 4'd13;
	localparam logic [BYTE_IDX_W-1:0] IDX_DATA      = 4'd14;

	// live configuration
	typedef struct packed {
		logic [31:0] sync_source;
		logic [6:0]  payload_type;
		logic [15:0] single_limit;
		logic [15:0] fragment_chunk;
		logic [15:0] timestamp_step;
	} cfg_t;

	// one classified input byte, handed from front to back
	typedef struct packed {
		logic        has_hdr;
		logic        has_fu;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
		logic [7:0]  data;
		logic        last_pkt;
		logic        last_nal;
	} cmd_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hdl/rtpfu_front.sv =====
// front end: classifies nal bytes, keeps packet state, issues emit commands
module rtpfu_front
	import rtpfu_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        first_of_nal,
	input  logic [15:0] nal_length,
	output logic        cmd_push,
	output cmd_t        cmd
);

	localparam int LW   = LENGTH_BITS;
	localparam int CMPW = (LW > 16) ? LW : 16;

	logic [15:0]   seq_q;
	logic [31:0]   ts_q;
	logic [7:0]    hdr_q;
	logic [LW-1:0] nal_left_q;
	logic [LW-1:0] chunk_left_q;
	logic          frag_q;
	logic          first_pend_q;

	logic [LW+15:0] len_wide;
	logic [LW-1:0]  len_raw;
	logic [LW-1:0]  len;
	logic [15:0]    chunk_cfg;
	logic           is_end;
	logic [LW-1:0]  chunk_cur;
	logic           fin;

	logic [15:0]   seq_d;
	logic [31:0]   ts_d;
	logic [7:0]    hdr_d;
	logic [LW-1:0] nal_left_d;
	logic [LW-1:0] chunk_left_d;
	logic          frag_d;
	logic          first_pend_d;

	// length field, low LENGTH_BITS, zero read as one
	assign len_wide  = {{LW{1'b0}}, nal_length};
	assign len_raw   = len_wide[LW-1:0];
	assign len       = (len_raw == '0) ? LW'(1) : len_raw;
	assign chunk_cfg = (cfg.fragment_chunk == 16'd0) ? 16'd1 : cfg.fragment_chunk;
	assign is_end    = CMPW'(nal_left_q) <= CMPW'(chunk_cfg);
	assign chunk_cur = (chunk_left_q != '0) ? chunk_left_q :
	                   (is_end ? nal_left_q : LW'(chunk_cfg));

	// classification and next state
	always_comb begin
		seq_d        = seq_q;
		ts_d         = ts_q;
		hdr_d        = hdr_q;
		nal_left_d   = nal_left_q;
		chunk_left_d = chunk_left_q;
		frag_d       = frag_q;
		first_pend_d = first_pend_q;
		fin          = 1'b0;
		cmd_push     = 1'b0;
		cmd.has_hdr  = 1'b0;
		cmd.has_fu   = 1'b0;
		cmd.seq      = seq_q;
		cmd.ts       = ts_q;
		cmd.fu_ind   = {hdr_q[7:5], FU_A_TYPE};
		cmd.fu_hdr   = {3'b000, hdr_q[4:0]};
		cmd.data     = data_byte;
		cmd.last_pkt = 1'b0;
		cmd.last_nal = 1'b0;
		if (accept) begin
			if (first_of_nal) begin
				hdr_d        = data_byte;
				chunk_left_d = '0;
				nal_left_d   = len - LW'(1);
				if ((CMPW'(len) > CMPW'(cfg.single_limit)) && (len != LW'(1))) begin
					// long nal: wait for the first payload byte to open a fragment
					frag_d       = 1'b1;
					first_pend_d = 1'b1;
				end else begin
					frag_d       = 1'b0;
					first_pend_d = 1'b0;
					cmd_push     = 1'b1;
					cmd.has_hdr  = 1'b1;
					seq_d        = seq_q + 16'd1;
					cmd.last_pkt = (len == LW'(1));
					cmd.last_nal = (len == LW'(1));
					fin          = (len == LW'(1));
				end
			end else if (nal_left_q != '0) begin
				cmd_push   = 1'b1;
				nal_left_d = nal_left_q - LW'(1);
				if (!frag_q) begin
					cmd.last_pkt = (nal_left_q == LW'(1));
					cmd.last_nal = (nal_left_q == LW'(1));
					fin          = (nal_left_q == LW'(1));
				end else begin
					// fragment opening: rtp header plus fu indicator and fu header
					if (chunk_left_q == '0) begin
						cmd.has_hdr  = 1'b1;
						cmd.has_fu   = 1'b1;
						seq_d        = seq_q + 16'd1;
						first_pend_d = 1'b0;
						cmd.fu_hdr   = {3'b000, hdr_q[4:0]}
						             | (first_pend_q ? FU_START_BIT : 8'h00)
						             | (is_end ? FU_END_BIT : 8'h00);
					end
					chunk_left_d = chunk_cur - LW'(1);
					cmd.last_pkt = (chunk_cur == LW'(1)) || (nal_left_q == LW'(1));
					cmd.last_nal = (nal_left_q == LW'(1));
					fin          = (nal_left_q == LW'(1));
				end
			end
			// nal done: advance timestamp, leave fragment mode
			if (fin) begin
				ts_d         = ts_q + 32'(cfg.timestamp_step);
				frag_d       = 1'b0;
				first_pend_d = 1'b0;
				chunk_left_d = '0;
			end
		end
	end

	// packet state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SEQ_RESET;
			ts_q         <= '0;
			hdr_q        <= '0;
			nal_left_q   <= '0;
			chunk_left_q <= '0;
			frag_q       <= 1'b0;
			first_pend_q <= 1'b0;
		end else begin
			seq_q        <= seq_d;
			ts_q         <= ts_d;
			hdr_q        <= hdr_d;
			nal_left_q   <= nal_left_d;
			chunk_left_q <= chunk_left_d;
			frag_q       <= frag_d;
			first_pend_q <= first_pend_d;
		end
	end

endmodule

// ===== hdl/rtpfu_queue.sv =====
// short command queue between front and back end
module rtpfu_queue
	import rtpfu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head_cmd,
	output q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/rtpfu_back.sv =====
// back end: expands commands into rtp packet beats through an output register
module rtpfu_back
	import rtpfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_stat_t     q_stat,
	input  cmd_t        head_cmd,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  packet_byte,
	output logic        last_of_packet,
	output logic        last_of_nal
);

	cmd_t                  cmd_q;
	logic                  busy_q;
	logic [BYTE_IDX_W-1:0] idx_q;
	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  lp_q;
	logic                  ln_q;

	logic       out_free;
	logic       emit;
	logic [7:0] cur_byte;

	assign out_free = !out_valid_q || pop;
	assign emit     = busy_q && out_free;
	assign q_pop    = !q_stat.empty && (!busy_q || (emit && idx_q == IDX_DATA));

	// byte select for the current position
	always_comb begin
		case (idx_q)
			4'd0:         cur_byte = RTP_VERSION_BYTE;
			4'd1:         cur_byte = {1'b0, cfg.payload_type};
			4'd2:         cur_byte = cmd_q.seq[15:8];
			4'd3:         cur_byte = cmd_q.seq[7:0];
			4'd4:         cur_byte = cmd_q.ts[31:24];
			4'd5:         cur_byte = cmd_q.ts[23:16];
			4'd6:         cur_byte = cmd_q.ts[15:8];
			4'd7:         cur_byte = cmd_q.ts[7:0];
			4'd8:         cur_byte = cfg.sync_source[31:24];
			4'd9:         cur_byte = cfg.sync_source[23:16];
			4'd10:        cur_byte = cfg.sync_source[15:8];
			IDX_HDR_LAST: cur_byte = cfg.sync_source[7:0];
			IDX_FU_IND:   cur_byte = cmd_q.fu_ind;
			IDX_FU_HDR:   cur_byte = cmd_q.fu_hdr;
			default:      cur_byte = cmd_q.data;
		endcase
	end

	// command register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= head_cmd;
		end
	end

	// position sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= IDX_DATA;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= head_cmd.has_hdr ? IDX_HDR_FIRST : IDX_DATA;
		end else if (emit) begin
			if (idx_q == IDX_DATA) begin
				busy_q <= 1'b0;
			end else if (idx_q == IDX_HDR_LAST && !cmd_q.has_fu) begin
				idx_q <= IDX_DATA;
			end else begin
				idx_q <= idx_q + BYTE_IDX_W'(1);
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= cur_byte;
			lp_q   <= (idx_q == IDX_DATA) && cmd_q.last_pkt;
			ln_q   <= (idx_q == IDX_DATA) && cmd_q.last_nal;
		end
	end

	assign empty          = !out_valid_q;
	assign packet_byte    = byte_q;
	assign last_of_packet = lp_q;
	assign last_of_nal    = ln_q;

endmodule

// ===== hdl/h264_rtp_fua_packetizer_top.sv =====
// top level of the h.264 rtp fu-a packetizer: config registers, front, queue, back
//
// Input channel: one nal byte per beat on data_byte; first_of_nal marks the nal
// header byte, and nal_length (total bytes, header included) is read on that beat.
// A beat is taken when push is high and full is low.
// Output channel: rtp packet bytes, oldest first, on packet_byte with
// last_of_packet and last_of_nal; a beat is taken when pop is high and empty low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 ssrc,
// 1 payload type, 2 single limit, 3 fragment chunk, 4 timestamp step); write only
// while the block is idle.
// Throughput: payload bytes pass at one per cycle while the receiver pops. Each packet
// start makes the back end first send the 12-byte rtp header (plus the fu indicator
// and fu header for an fu-a fragment); the front keeps taking bytes into the command
// queue (QUEUE_DEPTH entries) and raises full when all entries are taken.
// An accepted byte passes a queue slot, the command register and the output register.
// Reset clears all packet state (sequence number 1, timestamp 0) and loads the
// default register values. A stalled receiver holds the output register; the
// queue then fills and full stops the input side, with no beat lost.
module h264_rtp_fua_packetizer_top
	import rtpfu_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_nal,
	input  logic [15:0]            nal_length,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             packet_byte,
	output logic                   last_of_packet,
	output logic                   last_of_nal
);

	cfg_t    cfg_q;
	logic    accept;
	logic    cmd_push;
	cmd_t    cmd;
	cmd_t    head_cmd;
	logic    q_pop;
	q_stat_t q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_source    <= DEF_SYNC_SOURCE;
			cfg_q.payload_type   <= DEF_PAYLOAD_TYPE;
			cfg_q.single_limit   <= DEF_SINGLE_LIMIT;
			cfg_q.fragment_chunk <= DEF_FRAGMENT_CHUNK;
			cfg_q.timestamp_step <= DEF_TIMESTAMP_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_SOURCE:    cfg_q.sync_source    <= cfg_data;
				REG_PAYLOAD_TYPE:   cfg_q.payload_type   <= cfg_data[6:0];
				REG_SINGLE_LIMIT:   cfg_q.single_limit   <= cfg_data[15:0];
				REG_FRAGMENT_CHUNK: cfg_q.fragment_chunk <= cfg_data[15:0];
				REG_TIMESTAMP_STEP: cfg_q.timestamp_step <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	rtpfu_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.data_byte   (data_byte),
		.first_of_nal(first_of_nal),
		.nal_length  (nal_length),
		.cmd_push    (cmd_push),
		.cmd         (cmd)
	);

	rtpfu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.push_cmd(cmd),
		.pop     (q_pop),
		.head_cmd(head_cmd),
		.stat    (q_stat)
	);

	rtpfu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_stat        (q_stat),
		.head_cmd      (head_cmd),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.packet_byte   (packet_byte),
		.last_of_packet(last_of_packet),
		.last_of_nal   (last_of_nal)
	);

	// end of a nal always closes its packet
	a_nal_closes_packet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last_of_nal |-> last_of_packet)
		else $error("last_of_nal without last_of_packet");

	// front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_stat.full)
		else $error("command queue overflow");

	// back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command queue underflow");

endmodule

// ===== tb/tb.sv =====
// testbench for the h.264 rtp fu-a packetizer: directed table, then random nal streams
module tb;
	import rtpfu_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int PHASE_BYTES   = 32;
	localparam int PHASES        = 4;
	localparam int MAX_REPORTS   = 10;
	localparam int PLAN_ROWS     = 33;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	// one row of the directed plan: an input beat or a register write
	typedef struct packed {
		row_kind_t               kind;
		logic [7:0]              data;
		logic                    first;
		logic [15:0]             len;
		int                      beats;
		logic [CFG_INDEX_W-1:0]  reg_idx;
		logic [31:0]             value;
	} plan_row_t;

	// one output beat of the packet stream
	typedef struct packed {
		logic [7:0] data;
		logic       pkt_end;
		logic       nal_end;
	} pkt_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   push;
	logic                   full;
	logic [7:0]             data_byte;
	logic                   first_of_nal;
	logic [15:0]            nal_length;
	logic                   empty;
	logic                   pop;
	logic [7:0]             packet_byte;
	logic                   last_of_packet;
	logic                   last_of_nal;

	h264_rtp_fua_packetizer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.first_of_nal   (first_of_nal),
		.nal_length     (nal_length),
		.empty          (empty),
		.pop            (pop),
		.packet_byte    (packet_byte),
		.last_of_packet (last_of_packet),
		.last_of_nal    (last_of_nal)
	);

	// packetizer shadow: configuration and packet state
	logic [31:0] ssrc_val;
	logic [6:0]  pt_val;
	logic [15:0] limit_val;
	logic [15:0] chunk_val;
	logic [15:0] step_val;
	logic [15:0] seq_no;
	logic [31:0] stamp;
	logic [7:0]  nal_hdr;
	logic [15:0] nal_left;
	logic [15:0] chunk_left;
	logic        fu_mode;
	logic        fu_start_due;

	pkt_beat_t packet_beats_due[$];

	int  mismatches;
	int  bytes_in;
	int  nal_starts;
	int  reg_writes;
	int  beats_out;
	int  packets_out;
	int  cycle_count;
	int  tx_steady;
	logic hold_arm;

	// directed plan: defaults after reset, then the extreme settings
	plan_row_t directed_plan [0:PLAN_ROWS-1] = '{
		// stray byte right after reset, header-only and zero-length nals
		'{ROW_BEAT, 8'h55, 1'b0, 16'h1234, 0,  REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'hFF, 1'b1, 16'h0001, 13, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h00, 1'b1, 16'h0000, 13, REG_SYNC_SOURCE, 32'd0},
		// short nal sent whole, then a stray byte
		'{ROW_BEAT, 8'h41, 1'b1, 16'h0003, 13, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'hAA, 1'b0, 16'hFFFF, -1, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h5A, 1'b0, 16'h0000, -1, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h33, 1'b0, 16'h0007, 0,  REG_SYNC_SOURCE, 32'd0},
		// longest nal goes fragmented, then is abandoned by a new nal
		'{ROW_BEAT, 8'h7C, 1'b1, 16'hFFFF, 0,  REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h12, 1'b0, 16'h0000, 15, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h34, 1'b0, 16'h0000, -1, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h68, 1'b1, 16'h0002, 13, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h99, 1'b0, 16'h0000, -1, REG_SYNC_SOURCE, 32'd0},
		// one above and exactly at the single-packet limit
		'{ROW_BEAT, 8'h45, 1'b1, 16'd1389, 0,  REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h46, 1'b1, 16'd1388, 13, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h06, 1'b1, 16'h0001, 13, REG_SYNC_SOURCE, 32'd0},
		// all-ones registers, zero limit and zero chunk
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_SYNC_SOURCE,    32'hFFFF_FFFF},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_PAYLOAD_TYPE,   32'd127},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_SINGLE_LIMIT,   32'd0},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_FRAGMENT_CHUNK, 32'd0},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_TIMESTAMP_STEP, 32'hFFFF},
		'{ROW_BEAT, 8'h1F, 1'b1, 16'h0001, 13, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'hE5, 1'b1, 16'h0003, 0,  REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'hAB, 1'b0, 16'h0000, 15, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'hCD, 1'b0, 16'h5555, 15, REG_SYNC_SOURCE, 32'd0},
		// all-zero ssrc, type and step, largest limit and chunk
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_SYNC_SOURCE,    32'd0},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_PAYLOAD_TYPE,   32'd0},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_SINGLE_LIMIT,   32'hFFFF},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_FRAGMENT_CHUNK, 32'hFFFF},
		'{ROW_CFG,  8'h00, 1'b0, 16'h0000, 0,  REG_TIMESTAMP_STEP, 32'd0},
		'{ROW_BEAT, 8'h80, 1'b1, 16'h0004, 13, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h01, 1'b0, 16'h0000, -1, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h02, 1'b0, 16'h0000, -1, REG_SYNC_SOURCE, 32'd0},
		'{ROW_BEAT, 8'h03, 1'b0, 16'h0000, -1, REG_SYNC_SOURCE, 32'd0}
	};

	// clock, period 2
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d packet bytes still due",
				cycle_count, packet_beats_due.size());
			$display("FAIL h264_rtp_fua_packetizer_top");
			$finish;
		end
	end

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %0d at packet byte %0d: %s expected %0h got %0h",
				mismatches, beats_out, what, want, got);
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void emit(input logic [7:0] b, input logic pkt_end, input logic nal_end);
		pkt_beat_t x;
		x.data = b;
		x.pkt_end = pkt_end;
		x.nal_end = nal_end;
		packet_beats_due.push_back(x);
	endfunction

	// 12-byte rtp header, sequence number moves on per packet
	function automatic void put_rtp_header();
		emit(RTP_VERSION_BYTE, 1'b0, 1'b0);
		emit({1'b0, pt_val}, 1'b0, 1'b0);
		emit(seq_no[15:8], 1'b0, 1'b0);
		emit(seq_no[7:0], 1'b0, 1'b0);
		emit(stamp[31:24], 1'b0, 1'b0);
		emit(stamp[23:16], 1'b0, 1'b0);
		emit(stamp[15:8], 1'b0, 1'b0);
		emit(stamp[7:0], 1'b0, 1'b0);
		emit(ssrc_val[31:24], 1'b0, 1'b0);
		emit(ssrc_val[23:16], 1'b0, 1'b0);
		emit(ssrc_val[15:8], 1'b0, 1'b0);
		emit(ssrc_val[7:0], 1'b0, 1'b0);
		seq_no = seq_no + 16'd1;
	endfunction

	function automatic void close_nal();
		stamp = stamp + {16'd0, step_val};
		fu_mode = 1'b0;
		fu_start_due = 1'b0;
		chunk_left = 16'd0;
	endfunction

	// packet bytes released by one accepted input byte; returns their count
	function automatic int packetize(input logic [7:0] d, input logic f, input logic [15:0] l);
		int          start;
		logic [15:0] len;
		logic [15:0] chunk;
		logic        is_end;
		logic [7:0]  fu_hdr;
		start = packet_beats_due.size();
		if (f) begin
			nal_starts++;
			len = (l == 16'd0) ? 16'd1 : l;
			nal_hdr = d;
			chunk_left = 16'd0;
			nal_left = len - 16'd1;
			if (len > limit_val && len >= 16'd2) begin
				// too long: header byte is held back for the fu bytes
				fu_mode = 1'b1;
				fu_start_due = 1'b1;
			end else begin
				fu_mode = 1'b0;
				fu_start_due = 1'b0;
				put_rtp_header();
				if (nal_left == 16'd0) begin
					emit(d, 1'b1, 1'b1);
					close_nal();
				end else begin
					emit(d, 1'b0, 1'b0);
				end
			end
		end else if (nal_left != 16'd0) begin
			if (!fu_mode) begin
				nal_left = nal_left - 16'd1;
				if (nal_left == 16'd0) begin
					emit(d, 1'b1, 1'b1);
					close_nal();
				end else begin
					emit(d, 1'b0, 1'b0);
				end
			end else begin
				// fragment start: rtp header, fu indicator, fu header
				if (chunk_left == 16'd0) begin
					chunk = (chunk_val == 16'd0) ? 16'd1 : chunk_val;
					is_end = (nal_left <= chunk);
					fu_hdr = {3'b000, nal_hdr[4:0]};
					if (fu_start_due)
						fu_hdr = fu_hdr | FU_START_BIT;
					if (is_end)
						fu_hdr = fu_hdr | FU_END_BIT;
					chunk_left = is_end ? nal_left : chunk;
					fu_start_due = 1'b0;
					put_rtp_header();
					emit({nal_hdr[7:5], FU_A_TYPE}, 1'b0, 1'b0);
					emit(fu_hdr, 1'b0, 1'b0);
				end
				chunk_left = chunk_left - 16'd1;
				nal_left = nal_left - 16'd1;
				emit(d, (chunk_left == 16'd0) || (nal_left == 16'd0), nal_left == 16'd0);
				if (nal_left == 16'd0)
					close_nal();
			end
		end
		return packet_beats_due.size() - start;
	endfunction

	// offer one input beat until taken, then maybe idle
	task automatic offer_byte(input logic [7:0] d, input logic f, input logic [15:0] l,
		output int n);
		int gap;
		push <= 1'b1;
		data_byte <= d;
		first_of_nal <= f;
		nal_length <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n = packetize(d, f, l);
		bytes_in++;
		gap = 0;
		if (tx_steady > 0)
			tx_steady--;
		else if ($urandom_range(0, 15) == 0)
			tx_steady = $urandom_range(20, 60);
		else
			gap = gap_cycles();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, wait for every packet byte, then let the block settle
	task automatic drain();
		if (push)
			push <= 1'b0;
		while (packet_beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SYNC_SOURCE:    ssrc_val = value;
			REG_PAYLOAD_TYPE:   pt_val = value[6:0];
			REG_SINGLE_LIMIT:   limit_val = value[15:0];
			REG_FRAGMENT_CHUNK: chunk_val = value[15:0];
			REG_TIMESTAMP_STEP: step_val = value[15:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// receiver: check each popped beat, random pop gaps and one long hold
	initial begin : sink
		int        gap_left;
		int        steady_left;
		int        hold_left;
		logic      held;
		pkt_beat_t want;
		gap_left = 0;
		steady_left = 0;
		hold_left = 0;
		held = 1'b0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (packet_beats_due.size() == 0) begin
					note_mismatch("packet byte with nothing due", 0, int'(packet_byte));
				end else begin
					want = packet_beats_due.pop_front();
					if (packet_byte !== want.data)
						note_mismatch("packet_byte", int'(want.data), int'(packet_byte));
					if (last_of_packet !== want.pkt_end)
						note_mismatch("last_of_packet", int'(want.pkt_end),
							int'(last_of_packet));
					if (last_of_nal !== want.nal_end)
						note_mismatch("last_of_nal", int'(want.nal_end), int'(last_of_nal));
				end
				beats_out++;
				if (last_of_packet)
					packets_out++;
			end
			if (hold_arm && !held) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (steady_left > 0)
					steady_left--;
				else if ($urandom_range(0, 31) == 0)
					steady_left = $urandom_range(40, 150);
				else
					gap_left = gap_cycles();
			end
		end
	end

	// stimulus: reset, directed plan, random phases, end of run
	initial begin : stimulus
		int          n;
		int          i;
		int          phase;
		int          budget;
		int          len;
		int          k;
		int          r;
		logic        open_nal;
		logic [31:0] lim;
		logic [31:0] chk;
		logic [31:0] stp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SYNC_SOURCE;
		cfg_data = '0;
		push = 1'b0;
		data_byte = 8'd0;
		first_of_nal = 1'b0;
		nal_length = 16'd0;
		hold_arm = 1'b0;
		mismatches = 0;
		bytes_in = 0;
		nal_starts = 0;
		reg_writes = 0;
		beats_out = 0;
		packets_out = 0;
		cycle_count = 0;
		tx_steady = 0;
		ssrc_val = DEF_SYNC_SOURCE;
		pt_val = DEF_PAYLOAD_TYPE;
		limit_val = DEF_SINGLE_LIMIT;
		chunk_val = DEF_FRAGMENT_CHUNK;
		step_val = DEF_TIMESTAMP_STEP;
		seq_no = SEQ_RESET;
		stamp = 32'd0;
		nal_hdr = 8'd0;
		nal_left = 16'd0;
		chunk_left = 16'd0;
		fu_mode = 1'b0;
		fu_start_due = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (i = 0; i < PLAN_ROWS; i++) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
			end else begin
				offer_byte(directed_plan[i].data, directed_plan[i].first,
					directed_plan[i].len, n);
				if (directed_plan[i].beats >= 0 && n != directed_plan[i].beats)
					note_mismatch("bytes released by directed row", directed_plan[i].beats, n);
			end
		end

		// random phases, each with its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: begin
					lim = $urandom_range(1, 6);
					chk = $urandom_range(1, 4);
				end
				1: begin
					lim = $urandom_range(0, 2);
					chk = 32'd1;
				end
				2: begin
					lim = 32'hFFFF;
					chk = 32'hFFFF;
				end
				default: begin
					lim = $urandom_range(1, 12);
					chk = $urandom_range(0, 12);
				end
			endcase
			stp = (phase == 1) ? 32'hFFFF : $urandom_range(0, 65535);
			write_reg(REG_SYNC_SOURCE, $urandom());
			write_reg(REG_PAYLOAD_TYPE, $urandom_range(0, 127));
			write_reg(REG_SINGLE_LIMIT, lim);
			write_reg(REG_FRAGMENT_CHUNK, chk);
			write_reg(REG_TIMESTAMP_STEP, stp);
			if (phase == 0)
				hold_arm <= 1'b1;
			budget = 0;
			open_nal = 1'b0;
			while (budget < PHASE_BYTES || open_nal) begin
				r = $urandom_range(0, 99);
				if (r < 8 && !open_nal) begin
					// stray byte between nals
					offer_byte(8'($urandom_range(0, 255)), 1'b0,
						16'($urandom_range(0, 65535)), n);
				end else if (r < 18) begin
					// long nal cut short by the next nal
					len = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(13, 65535);
					offer_byte(8'($urandom_range(0, 255)), 1'b1, 16'(len), n);
					k = $urandom_range(0, 3);
					budget += k + 1;
					repeat (k)
						offer_byte(8'($urandom_range(0, 255)), 1'b0,
							16'($urandom_range(0, 65535)), n);
					open_nal = 1'b1;
				end else begin
					// complete nal, small sizes
					len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
					offer_byte(8'($urandom_range(0, 255)), 1'b1, 16'(len), n);
					k = (len == 0) ? 0 : len - 1;
					budget += k + 1;
					repeat (k)
						offer_byte(8'($urandom_range(0, 255)), 1'b0,
							16'($urandom_range(0, 65535)), n);
					open_nal = 1'b0;
				end
			end
		end

		// end of run
		drain();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (packet_beats_due.size() != 0)
			note_mismatch("packet bytes never seen", packet_beats_due.size(), 0);
		$display("covered %0d input bytes over %0d nal starts, %0d register writes",
			bytes_in, nal_starts, reg_writes);
		$display("checked %0d packet bytes in %0d packets, %0d mismatches",
			beats_out, packets_out, mismatches);
		if (mismatches == 0) begin
			$display("PASS h264_rtp_fua_packetizer_top");
		end else begin
			$display("FAIL h264_rtp_fua_packetizer_top");
		end
		$finish;
	end

endmodule
